/* rtl/cbb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants of the clipped box blur
// Field widths, register indexes and the structs passed between the parts.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 13;
  localparam int RADIUS_BITS   = 3;
  localparam int ERAD_BITS     = 4;   // effective radius, up to 7
  localparam int PIXEL_BITS    = 24;
  localparam int ITEMS_BITS    = 23;
  localparam int LIN_BITS      = 25;  // row * width + column
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 2;

  localparam int MAX_HEIGHT     = 4096;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 7;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RST = 3'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 2'd2;

  // effective (clamped) geometry
  typedef struct packed {
    logic [WIDTH_BITS-1:0]  w;
    logic [HEIGHT_BITS-1:0] h;
    logic [ERAD_BITS-1:0]   r;
  } cbb_cfg_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic [PIXEL_BITS-1:0]  pixel;
    logic [HEIGHT_BITS-1:0] row;
    logic [WIDTH_BITS-1:0]  col;
    logic                   emit;
    logic                   frame_end;
  } cbb_item_t;

endpackage
`default_nettype wire

/* rtl/cbb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_queue: two-entry queue between front and back
// Lets the front keep taking transactions while the back works.
// ----------------------------------------------------------------------------
module cbb_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [DW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output logic [DW-1:0]      pop_data
);

  logic [DW-1:0] ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/cbb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_front: position tracking and classification
// Counts transactions in the frame, picks the ring slot and decides whether
// the transaction releases a result, and for which pixel.
// ----------------------------------------------------------------------------
module cbb_front import cbb_pkg::*; #(
  parameter int RING_DEPTH = 15360,
  parameter int AW         = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cbb_cfg_t              cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIXEL_BITS-1:0] in_pixel,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output cbb_item_t                  q_item,
  output logic [AW-1:0]              q_addr
);

  logic [ITEMS_BITS-1:0]  items_r, items_nxt;
  logic [HEIGHT_BITS-1:0] row_r, row_nxt;
  logic [WIDTH_BITS-1:0]  col_r, col_nxt;
  logic [AW-1:0]          waddr_r, waddr_nxt;
  logic [15:0]            lag;
  logic [LIN_BITS-1:0]    total;
  logic                   emit;
  logic                   push;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign push     = in_valid && q_ready;

  always_comb begin
    lag   = 16'(cfg.r) * 16'(cfg.w) + 16'(cfg.r);
    total = LIN_BITS'(cfg.w) * LIN_BITS'(cfg.h) + LIN_BITS'(lag);
    emit  = (LIN_BITS'(items_r) >= LIN_BITS'(lag)) && (row_r < cfg.h);

    q_item.pixel     = in_pixel;
    q_item.row       = row_r;
    q_item.col       = col_r;
    q_item.emit      = emit;
    q_item.frame_end = emit && (row_r == cfg.h - 13'd1) && (col_r == cfg.w - 11'd1);
    q_addr           = waddr_r;

    row_nxt = row_r;
    col_nxt = col_r;
    if (emit) begin
      if ((12'(col_r) + 12'd1) >= 12'(cfg.w)) begin
        col_nxt = '0;
        row_nxt = row_r + 13'd1;
      end else begin
        col_nxt = col_r + 11'd1;
      end
    end
    items_nxt = items_r + 23'd1;
    waddr_nxt = (waddr_r == AW'(RING_DEPTH - 1)) ? '0 : waddr_r + AW'(1);
    // end of frame including the drain transactions
    if (LIN_BITS'(items_nxt) >= total) begin
      items_nxt = '0;
      row_nxt   = '0;
      col_nxt   = '0;
      waddr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      waddr_r <= '0;
    end else if (push) begin
      items_r <= items_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      waddr_r <= waddr_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/cbb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_back: line store, window walk and divider
// Writes each pixel into the ring, walks the clipped window one read per
// cycle, then divides the three sums bit-serially by the pixel count.
// ----------------------------------------------------------------------------
module cbb_back import cbb_pkg::*; #(
  parameter int MAX_RADIUS = 7,
  parameter int RING_DEPTH = 15360,
  parameter int AW         = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cbb_cfg_t              cfg,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire cbb_item_t             q_item,
  input  wire logic [AW-1:0]         q_addr,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIXEL_BITS-1:0]      out_data,
  output logic                       out_last
);

  localparam int WinMax     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SumBits    = $clog2(WinMax * 255 + 1);
  localparam int CntBits    = $clog2(WinMax + 1);
  localparam int DBits      = $clog2(SumBits);
  // ring slot by reciprocal: quotient estimate is at most one short
  localparam int RecipShift = LIN_BITS + 1;
  localparam int MBits      = RecipShift + 1 - $clog2(RING_DEPTH);
  localparam int PBits      = RecipShift + MBits;
  localparam logic [MBits-1:0] RecipMul =
    MBits'((64'd1 << RecipShift) / 64'(RING_DEPTH));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;
  localparam logic [2:0] ST_RED   = 3'd7;

  logic [PIXEL_BITS-1:0] mem [RING_DEPTH];
  logic [PIXEL_BITS-1:0] mem_q_r;

  logic [2:0]             state_r, state_nxt;
  cbb_item_t              item_r, item_nxt;
  logic [HEIGHT_BITS-1:0] rlo_r, rlo_nxt, rhi_r, rhi_nxt, i_r, i_nxt;
  logic [WIDTH_BITS-1:0]  clo_r, clo_nxt, chi_r, chi_nxt, j_r, j_nxt;
  logic [LIN_BITS:0]      lin_r, lin_nxt;
  logic [MBits-1:0]       quo_r, quo_nxt;
  logic [AW-1:0]          addr_r, addr_nxt, rowaddr_r, rowaddr_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic [SumBits-1:0]     sr_r, sr_nxt, sg_r, sg_nxt, sb_r, sb_nxt;
  logic [CntBits-1:0]     cnt_r, cnt_nxt;
  logic [CntBits:0]       remr_r, remr_nxt, remg_r, remg_nxt, remb_r, remb_nxt;
  logic [DBits-1:0]       dstep_r, dstep_nxt;
  logic                   ov_r, ov_nxt, olast_r, olast_nxt;
  logic [PIXEL_BITS-1:0]  od_r, od_nxt;

  logic                   mem_we, rd_en;
  logic [HEIGHT_BITS:0]   rhi_t, hm1;
  logic [WIDTH_BITS:0]    chi_t, wm1;
  logic [HEIGHT_BITS-1:0] rlo_c, rhi_c;
  logic [WIDTH_BITS-1:0]  clo_c, chi_c;
  logic [PBits-1:0]       prod;
  logic [MBits-1:0]       quo_c;
  logic [LIN_BITS:0]      remx, rem_c;
  logic [AW:0]            rowstep;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_last  = olast_r;
  assign q_ready   = (state_r == ST_IDLE);
  assign mem_we    = q_valid && q_ready;
  assign rd_en     = (state_r == ST_WALK);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_addr] <= q_item.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[addr_r];
    end
  end

  // clipped window bounds of the pixel being worked on
  always_comb begin
    rlo_c = (item_r.row > 13'(cfg.r)) ? item_r.row - 13'(cfg.r) : '0;
    rhi_t = 14'(item_r.row) + 14'(cfg.r);
    hm1   = 14'(cfg.h) - 14'd1;
    rhi_c = (rhi_t < hm1) ? rhi_t[HEIGHT_BITS-1:0] : hm1[HEIGHT_BITS-1:0];
    clo_c = (item_r.col > 11'(cfg.r)) ? item_r.col - 11'(cfg.r) : '0;
    chi_t = 12'(item_r.col) + 12'(cfg.r);
    wm1   = 12'(cfg.w) - 12'd1;
    chi_c = (chi_t < wm1) ? chi_t[WIDTH_BITS-1:0] : wm1[WIDTH_BITS-1:0];
    prod  = PBits'(lin_r) * PBits'(RecipMul);
    quo_c = prod[PBits-1:RecipShift];
    remx  = lin_r - (LIN_BITS + 1)'(quo_r) * (LIN_BITS + 1)'(RING_DEPTH);
    rem_c = (remx >= (LIN_BITS + 1)'(RING_DEPTH)) ?
            remx - (LIN_BITS + 1)'(RING_DEPTH) : remx;
    rowstep = (AW + 1)'(rowaddr_r) + (AW + 1)'(cfg.w);
    if (rowstep >= (AW + 1)'(RING_DEPTH)) begin
      rowstep = rowstep - (AW + 1)'(RING_DEPTH);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    rlo_nxt     = rlo_r;
    rhi_nxt     = rhi_r;
    clo_nxt     = clo_r;
    chi_nxt     = chi_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    lin_nxt     = lin_r;
    quo_nxt     = quo_r;
    addr_nxt    = addr_r;
    rowaddr_nxt = rowaddr_r;
    rd_pend_nxt = rd_en;
    sr_nxt      = sr_r;
    sg_nxt      = sg_r;
    sb_nxt      = sb_r;
    cnt_nxt     = cnt_r;
    remr_nxt    = remr_r;
    remg_nxt    = remg_r;
    remb_nxt    = remb_r;
    dstep_nxt   = dstep_r;
    ov_nxt      = ov_r && !out_ready;
    od_nxt      = od_r;
    olast_nxt   = olast_r;

    // read data lands in the cycle after the walk issues it
    if (rd_pend_r) begin
      sr_nxt  = sr_r + SumBits'(mem_q_r[7:0]);
      sg_nxt  = sg_r + SumBits'(mem_q_r[15:8]);
      sb_nxt  = sb_r + SumBits'(mem_q_r[23:16]);
      cnt_nxt = cnt_r + CntBits'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          item_nxt  = q_item;
          sr_nxt    = '0;
          sg_nxt    = '0;
          sb_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = q_item.emit ? ST_START : ST_IDLE;
        end
      end
      ST_START: begin
        rlo_nxt   = rlo_c;
        rhi_nxt   = rhi_c;
        clo_nxt   = clo_c;
        chi_nxt   = chi_c;
        lin_nxt   = (LIN_BITS + 1)'(rlo_c) * (LIN_BITS + 1)'(cfg.w)
                  + (LIN_BITS + 1)'(clo_c);
        // a window left with no columns averages to zero
        state_nxt = (chi_c < clo_c) ? ST_OUT : ST_MOD;
      end
      ST_MOD: begin
        quo_nxt   = quo_c;
        state_nxt = ST_RED;
      end
      ST_RED: begin
        addr_nxt    = rem_c[AW-1:0];
        rowaddr_nxt = rem_c[AW-1:0];
        i_nxt       = rlo_r;
        j_nxt       = clo_r;
        state_nxt   = ST_WALK;
      end
      ST_WALK: begin
        if (j_r == chi_r) begin
          if (i_r == rhi_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt       = i_r + 13'd1;
            j_nxt       = clo_r;
            rowaddr_nxt = rowstep[AW-1:0];
            addr_nxt    = rowstep[AW-1:0];
          end
        end else begin
          j_nxt    = j_r + 11'd1;
          addr_nxt = (addr_r == AW'(RING_DEPTH - 1)) ? '0 : addr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        remr_nxt  = '0;
        remg_nxt  = '0;
        remb_nxt  = '0;
        dstep_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // restoring division, quotient shifts into the sum registers
        remr_nxt = {remr_r[CntBits-1:0], sr_r[SumBits-1]};
        remg_nxt = {remg_r[CntBits-1:0], sg_r[SumBits-1]};
        remb_nxt = {remb_r[CntBits-1:0], sb_r[SumBits-1]};
        sr_nxt   = sr_r << 1;
        sg_nxt   = sg_r << 1;
        sb_nxt   = sb_r << 1;
        if (remr_nxt >= (CntBits + 1)'(cnt_r)) begin
          remr_nxt  = remr_nxt - (CntBits + 1)'(cnt_r);
          sr_nxt[0] = 1'b1;
        end
        if (remg_nxt >= (CntBits + 1)'(cnt_r)) begin
          remg_nxt  = remg_nxt - (CntBits + 1)'(cnt_r);
          sg_nxt[0] = 1'b1;
        end
        if (remb_nxt >= (CntBits + 1)'(cnt_r)) begin
          remb_nxt  = remb_nxt - (CntBits + 1)'(cnt_r);
          sb_nxt[0] = 1'b1;
        end
        dstep_nxt = dstep_r + DBits'(1);
        if (dstep_r == DBits'(SumBits - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          od_nxt    = (cnt_r == '0) ? '0 : {sb_r[7:0], sg_r[7:0], sr_r[7:0]};
          olast_nxt = item_r.frame_end;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    rlo_r     <= rlo_nxt;
    rhi_r     <= rhi_nxt;
    clo_r     <= clo_nxt;
    chi_r     <= chi_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    lin_r     <= lin_nxt;
    quo_r     <= quo_nxt;
    addr_r    <= addr_nxt;
    rowaddr_r <= rowaddr_nxt;
    sr_r      <= sr_nxt;
    sg_r      <= sg_nxt;
    sb_r      <= sb_nxt;
    cnt_r     <= cnt_nxt;
    remr_r    <= remr_nxt;
    remg_r    <= remg_nxt;
    remb_r    <= remb_nxt;
    dstep_r   <= dstep_nxt;
    od_r      <= od_nxt;
    olast_r   <= olast_nxt;
  end

endmodule
`default_nettype wire

/* rtl/clipped_box_blur_rgb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_box_blur_rgb: box blur of an RGB raster stream, clipped at borders
// Front classifies transactions, a short queue decouples the back, which
// keeps the line ring, walks each window and divides the sums.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; the result for a pixel leaves R*W+R input
// transactions later, so after a frame the source sends that many filler
// transactions. A transaction that releases no result leaves the back ready
// for the next one. One that releases a result holds the back through address
// reduction (reciprocal multiply, then a correcting subtract), the walk of its
// clipped window (rows*cols ring reads, one per cycle, single read port),
// the bit-serial divider over 16 sum bits at the default maximum radius, and
// the start, drain and output control states.
// The ring is not cleared after reset; no clearing pass is needed.
module clipped_box_blur_rgb import cbb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [23:0]              in_tdata,   // red_in, green_in, blue_in
  input  wire logic                     in_tuser,   // filler
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [23:0]                   out_tdata,  // red_avg, green_avg, blue_avg
  output logic                          out_tlast,  // frame_end
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int RingDepth = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW        = $clog2(RingDepth);
  localparam int QW        = $bits(cbb_item_t) + AW;

  logic [WIDTH_BITS-1:0]  width_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic [RADIUS_BITS-1:0] radius_r;
  cbb_cfg_t               cfg;

  logic                   fq_valid, fq_ready, bq_valid, bq_ready;
  cbb_item_t              f_item, b_item;
  logic [AW-1:0]          f_addr, b_addr;
  logic [QW-1:0]          bq_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wdata[WIDTH_BITS-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[HEIGHT_BITS-1:0];
        REG_RADIUS: radius_r <= cfg_wdata[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      cfg.w = 11'd1;
    end else if (int'(width_r) > MAX_WIDTH) begin
      cfg.w = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      cfg.w = width_r;
    end
    if (height_r == '0) begin
      cfg.h = 13'd1;
    end else if (int'(height_r) > MAX_HEIGHT) begin
      cfg.h = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      cfg.h = height_r;
    end
    cfg.r = (int'(radius_r) > MAX_RADIUS) ? ERAD_BITS'(MAX_RADIUS) : 4'(radius_r);
  end

  // position is counted by transactions alone; in_tuser needs no handling
  cbb_front #(
    .RING_DEPTH (RingDepth),
    .AW         (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pixel (in_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (f_item),
    .q_addr   (f_addr)
  );

  cbb_queue #(
    .DW (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  ({f_addr, f_item}),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data)
  );

  assign b_item = bq_data[$bits(cbb_item_t)-1:0];
  assign b_addr = bq_data[QW-1:$bits(cbb_item_t)];

  cbb_back #(
    .MAX_RADIUS (MAX_RADIUS),
    .RING_DEPTH (RingDepth),
    .AW         (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (b_item),
    .q_addr    (b_addr),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

`ifndef SYNTHESIS
  a_push_is_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (fq_valid && fq_ready) |-> (in_tvalid && in_tready))
    else $error("queue push without an input transaction");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output transaction changed while stalled");

  a_eff_width : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg.w != '0) && (int'(cfg.w) <= MAX_WIDTH))
    else $error("effective width out of range");

  a_eff_radius : assert property (@(posedge clk) disable iff (!rst_n)
    int'(cfg.r) <= MAX_RADIUS)
    else $error("effective radius above maximum");

  a_frame_end_rows : assert property (@(posedge clk) disable iff (!rst_n)
    (fq_valid && fq_ready && f_item.frame_end) |-> f_item.emit)
    else $error("frame end marked on a transaction without a result");
`endif

endmodule
`default_nettype wire
